FILE: rtl/core/csx_pkg.sv
// Shared types and constants for the ChaCha20 stream XOR unit.
package csx_pkg;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        last_of_message;
  } csx_in_t;

  typedef struct packed {
    logic [63:0] result_word;
    logic [3:0]  result_valid_bytes;
    logic        result_last;
  } csx_out_t;

  // Sixteen 32-bit state words; word 0 sits in the low bits.
  typedef logic [15:0][31:0] csx_block_t;

  typedef struct packed {
    logic start;
  } csx_gen_ctrl_t;

  typedef struct packed {
    logic done;
  } csx_gen_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_EMIT
  } csx_state_t;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 64;

  localparam logic [CfgIndexW-1:0] CFG_KEY0   = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_KEY1   = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_KEY2   = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_KEY3   = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_NONCE0 = 3'd4;
  localparam logic [CfgIndexW-1:0] CFG_NONCE1 = 3'd5;

  localparam logic [3:0][31:0] SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

endpackage

FILE: rtl/core/chacha20_stream_xor_unit.sv
// Top level of the ChaCha20 stream XOR unit: registers, word sequencing and output stage.
//
//  channel  direction  signals                      accepted when
//  msg      in         msg_valid, msg_stall, msg    msg_valid && !msg_stall
//  res      out        res_valid, res_stall, res    res_valid && !res_stall
//  cfg      in         cfg_write, cfg_index, cfg_data  cfg_write
//
// A word that opens a keystream block waits in ST_ROUND while the core runs its rounds;
// the four lanes do one half quarter round per cycle. Other words go straight to ST_EMIT.
// One word is in the unit at a time; the result register lets the next word enter while a
// result waits. Reset (rst, synchronous) clears the counter, the position, the key and nonce
// registers and all handshake state. A stalled result holds the output register.
module chacha20_stream_xor_unit
  import csx_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = 10,
  parameter int WORD_BYTES    = 8
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 msg_valid,
  output logic                 msg_stall,
  input  csx_in_t              msg,
  output logic                 res_valid,
  input  logic                 res_stall,
  output csx_out_t             res,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  localparam int WordsPerBlock = 64 / WORD_BYTES;
  localparam int PosW          = $clog2(WordsPerBlock);
  localparam int ShiftBits     = 8 * WORD_BYTES;
  localparam logic [3:0] WordCnt = 4'(WORD_BYTES);

  csx_state_t    state;
  csx_state_t    state_next;

  logic [63:0]   key0, key1, key2, key3, nonce0;
  logic [31:0]   nonce1;
  logic [31:0]   block_counter;
  logic [PosW-1:0] word_position;
  logic [511:0]  ks_reg;
  csx_in_t       item;

  csx_block_t    init_state;
  csx_block_t    core_ks;
  csx_gen_ctrl_t gen_ctrl;
  csx_gen_stat_t gen_stat;

  logic          accept;
  logic          emit;
  logic [3:0]    byte_cnt;
  logic [63:0]   byte_mask;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init_state[i] = SIGMA[i];
    end
    init_state[4]  = key0[31:0];
    init_state[5]  = key0[63:32];
    init_state[6]  = key1[31:0];
    init_state[7]  = key1[63:32];
    init_state[8]  = key2[31:0];
    init_state[9]  = key2[63:32];
    init_state[10] = key3[31:0];
    init_state[11] = key3[63:32];
    init_state[12] = block_counter;
    init_state[13] = nonce0[31:0];
    init_state[14] = nonce0[63:32];
    init_state[15] = nonce1;
  end

  csx_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (gen_ctrl),
    .init_state (init_state),
    .stat       (gen_stat),
    .keystream  (core_ks)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (msg_valid) begin
          state_next = (word_position == '0) ? ST_ROUND : ST_EMIT;
        end
      end
      ST_ROUND: begin
        if (gen_stat.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!res_valid || !res_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    msg_stall      = 1'b1;
    accept         = 1'b0;
    emit           = 1'b0;
    gen_ctrl.start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        msg_stall      = 1'b0;
        accept         = msg_valid;
        gen_ctrl.start = msg_valid && (word_position == '0);
      end
      ST_ROUND: begin
        msg_stall = 1'b1;
      end
      ST_EMIT: begin
        emit = !res_valid || !res_stall;
      end
      default: msg_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key0   <= '0;
      key1   <= '0;
      key2   <= '0;
      key3   <= '0;
      nonce0 <= '0;
      nonce1 <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_KEY0:   key0   <= cfg_data;
        CFG_KEY1:   key1   <= cfg_data;
        CFG_KEY2:   key2   <= cfg_data;
        CFG_KEY3:   key3   <= cfg_data;
        CFG_NONCE0: nonce0 <= cfg_data;
        CFG_NONCE1: nonce1 <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= msg;
    end
  end

  // Byte counts above the word size are clamped for masking only.
  always_comb begin
    byte_cnt = (item.valid_bytes > WordCnt) ? WordCnt : item.valid_bytes;
    for (int i = 0; i < 8; i++) begin
      byte_mask[8*i +: 8] = (4'(i) < byte_cnt) ? 8'hff : 8'h00;
    end
  end

  // The keystream register shifts down one word after each use, so the
  // current word's keystream always sits in the low bytes.
  always_ff @(posedge clk) begin
    if (gen_stat.done) begin
      ks_reg <= core_ks;
    end else if (emit) begin
      ks_reg <= ks_reg >> ShiftBits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
      word_position <= '0;
    end else if (emit) begin
      if (item.last_of_message) begin
        block_counter <= '0;
        word_position <= '0;
      end else if (word_position == PosW'(WordsPerBlock - 1)) begin
        block_counter <= block_counter + 32'd1;
        word_position <= '0;
      end else begin
        word_position <= word_position + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= emit || (res_valid && res_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.result_word        <= (item.data_word ^ ks_reg[63:0]) & byte_mask;
      res.result_valid_bytes <= item.valid_bytes;
      res.result_last        <= item.last_of_message;
    end
  end

endmodule

FILE: rtl/core/csx_qr_lane.sv
// One quarter-round lane: does either the first or the second half of a quarter round.
module csx_qr_lane
  import csx_pkg::*;
(
  input  logic        second_half,
  input  logic [31:0] a_in,
  input  logic [31:0] b_in,
  input  logic [31:0] c_in,
  input  logic [31:0] d_in,
  output logic [31:0] a_out,
  output logic [31:0] b_out,
  output logic [31:0] c_out,
  output logic [31:0] d_out
);

  logic [31:0] dx;
  logic [31:0] bx;

  // The first half rotates by 16 and 12, the second half by 8 and 7.
  always_comb begin
    a_out = a_in + b_in;
    dx    = d_in ^ a_out;
    d_out = second_half ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
    c_out = c_in + d_out;
    bx    = b_in ^ c_out;
    b_out = second_half ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
  end

endmodule

FILE: rtl/core/csx_core.sv
// Block generator: four quarter-round lanes over the state, then the final feed-forward add.
module csx_core
  import csx_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = 10
)
(
  input  logic          clk,
  input  logic          rst,
  input  csx_gen_ctrl_t ctrl,
  input  csx_block_t    init_state,
  output csx_gen_stat_t stat,
  output csx_block_t    keystream
);

  localparam int Steps = 4 * DOUBLE_ROUNDS;
  localparam int StepW = $clog2(Steps);

  csx_block_t       x;
  csx_block_t       x_next;
  logic [StepW-1:0] step;
  logic             running;
  logic             done;
  logic             diag;
  logic             second_half;

  logic [3:0][31:0] la, lb, lc, ld;
  logic [3:0][31:0] oa, ob, oc, od;

  // Step bit 0 picks the half of the quarter round, bit 1 picks diagonal rounds.
  assign second_half = step[0];
  assign diag        = step[1];

  for (genvar j = 0; j < 4; j++) begin : g_lane
    localparam int BD = 4 + ((j + 1) % 4);
    localparam int CD = 8 + ((j + 2) % 4);
    localparam int DD = 12 + ((j + 3) % 4);

    assign la[j] = x[j];
    assign lb[j] = diag ? x[BD] : x[4 + j];
    assign lc[j] = diag ? x[CD] : x[8 + j];
    assign ld[j] = diag ? x[DD] : x[12 + j];

    csx_qr_lane u_lane (
      .second_half (second_half),
      .a_in        (la[j]),
      .b_in        (lb[j]),
      .c_in        (lc[j]),
      .d_in        (ld[j]),
      .a_out       (oa[j]),
      .b_out       (ob[j]),
      .c_out       (oc[j]),
      .d_out       (od[j])
    );
  end

  always_comb begin
    x_next = x;
    for (int j = 0; j < 4; j++) begin
      x_next[j] = oa[j];
      if (diag) begin
        x_next[4 + ((j + 1) % 4)]  = ob[j];
        x_next[8 + ((j + 2) % 4)]  = oc[j];
        x_next[12 + ((j + 3) % 4)] = od[j];
      end else begin
        x_next[4 + j]  = ob[j];
        x_next[8 + j]  = oc[j];
        x_next[12 + j] = od[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + StepW'(1);
        if (step == StepW'(Steps - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      x <= init_state;
    end else if (running) begin
      x <= x_next;
    end
  end

  // Merge the lanes' work: add the input words back in.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      keystream[i] = x[i] + init_state[i];
    end
  end

  assign stat.done = done;

endmodule

FILE: test/chacha20_stream_xor_unit_tb.sv
// Self-checking testbench for the ChaCha20 stream XOR unit with a keystream predictor.
`timescale 1ns / 100ps

module chacha20_stream_xor_unit_tb
  import csx_pkg::*;
();

  localparam int DOUBLE_ROUNDS = 10;
  localparam int WORDS_PER_BLOCK = 8;
  localparam int BLOCK_LATENCY = 4 * DOUBLE_ROUNDS + 3;

  class cipher_word_board;
    logic [63:0] key_word [4];
    logic [63:0] nonce_lo;
    logic [31:0] nonce_hi;
    logic [31:0] blk_count;
    int unsigned word_pos;
    logic [63:0] pad [8];
    logic [31:0] mix_state [16];
    csx_out_t    cipher_due [$];
    int unsigned mismatches;

    function new();
      for (int i = 0; i < 4; i++) key_word[i] = '0;
      nonce_lo = '0;
      nonce_hi = '0;
      blk_count = '0;
      word_pos = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CfgIndexW-1:0] idx, logic [63:0] value);
      case (idx)
        CFG_KEY0:   key_word[0] = value;
        CFG_KEY1:   key_word[1] = value;
        CFG_KEY2:   key_word[2] = value;
        CFG_KEY3:   key_word[3] = value;
        CFG_NONCE0: nonce_lo = value;
        CFG_NONCE1: nonce_hi = value[31:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] rotl(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void quarter_round(int a, int b, int c, int d);
      mix_state[a] += mix_state[b];
      mix_state[d] = rotl(mix_state[d] ^ mix_state[a], 16);
      mix_state[c] += mix_state[d];
      mix_state[b] = rotl(mix_state[b] ^ mix_state[c], 12);
      mix_state[a] += mix_state[b];
      mix_state[d] = rotl(mix_state[d] ^ mix_state[a], 8);
      mix_state[c] += mix_state[d];
      mix_state[b] = rotl(mix_state[b] ^ mix_state[c], 7);
    endfunction

    // Builds the 64-byte keystream block from the registers as they stand now.
    function void refill_pad();
      logic [31:0] init [16];
      for (int i = 0; i < 4; i++) begin
        init[i] = SIGMA[i];
        init[4 + 2 * i] = key_word[i][31:0];
        init[5 + 2 * i] = key_word[i][63:32];
      end
      init[12] = blk_count;
      init[13] = nonce_lo[31:0];
      init[14] = nonce_lo[63:32];
      init[15] = nonce_hi;
      for (int i = 0; i < 16; i++) mix_state[i] = init[i];
      for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
        quarter_round(0, 4, 8, 12);
        quarter_round(1, 5, 9, 13);
        quarter_round(2, 6, 10, 14);
        quarter_round(3, 7, 11, 15);
        quarter_round(0, 5, 10, 15);
        quarter_round(1, 6, 11, 12);
        quarter_round(2, 7, 8, 13);
        quarter_round(3, 4, 9, 14);
      end
      for (int i = 0; i < 8; i++) begin
        pad[i] = {mix_state[2 * i + 1] + init[2 * i + 1], mix_state[2 * i] + init[2 * i]};
      end
    endfunction

    function void predict_cipher_word(csx_in_t w);
      csx_out_t    e;
      int unsigned n;
      if (word_pos == 0) refill_pad();
      n = (w.valid_bytes > 4'd8) ? 8 : w.valid_bytes;
      e.result_word = '0;
      for (int i = 0; i < n; i++) begin
        e.result_word[8 * i +: 8] = w.data_word[8 * i +: 8] ^ pad[word_pos][8 * i +: 8];
      end
      e.result_valid_bytes = w.valid_bytes;
      e.result_last = w.last_of_message;
      cipher_due.push_back(e);
      if (w.last_of_message) begin
        blk_count = '0;
        word_pos = 0;
      end else begin
        word_pos++;
        if (word_pos >= WORDS_PER_BLOCK) begin
          word_pos = 0;
          blk_count = blk_count + 32'd1;
        end
      end
    endfunction

    function void check_cipher_word(csx_out_t got);
      csx_out_t e;
      if (cipher_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected word data %h bytes %0d last %b", $realtime,
                   got.result_word, got.result_valid_bytes, got.result_last);
        end
        return;
      end
      e = cipher_due.pop_front();
      if (got.result_word !== e.result_word ||
          got.result_valid_bytes !== e.result_valid_bytes ||
          got.result_last !== e.result_last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: word expected data %h bytes %0d last %b, got data %h bytes %0d last %b",
                   $realtime, e.result_word, e.result_valid_bytes, e.result_last,
                   got.result_word, got.result_valid_bytes, got.result_last);
        end
      end
    endfunction

    function int unsigned pending();
      return cipher_due.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 msg_valid = 1'b0;
  logic                 msg_stall;
  csx_in_t              msg = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  csx_out_t             res;
  logic                 cfg_write = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = CFG_KEY0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  cipher_word_board board;
  int unsigned      send_idle_pct = 0;
  int unsigned      stall_pct = 0;

  chacha20_stream_xor_unit #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS),
    .WORD_BYTES   (8)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .msg_valid(msg_valid),
    .msg_stall(msg_stall),
    .msg      (msg),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && !res_stall) board.check_cipher_word(res);
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic csx_in_t make_word(logic [63:0] data, logic [3:0] vb, logic last);
    csx_in_t w;
    w.data_word = data;
    w.valid_bytes = vb;
    w.last_of_message = last;
    return w;
  endfunction

  function automatic logic [63:0] random_data();
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(csx_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      msg_valid <= 1'b0;
      @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg <= w;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
    board.predict_cipher_word(w);
  endtask

  task automatic load_config(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                             logic [63:0] k3, logic [63:0] n0, logic [31:0] n1);
    logic [CfgIndexW-1:0] idx [6];
    logic [63:0]          val [6];
    idx = '{CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3, CFG_NONCE0, CFG_NONCE1};
    val = '{k0, k1, k2, k3, n0, {32'd0, n1}};
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      board.set_reg(idx[i], val[i]);
    end
    cfg_write <= 1'b0;
  endtask

  // Lets every expected word come out, then waits out a block computation
  // so the unit is surely idle.
  task automatic drain_words();
    msg_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (2 * BLOCK_LATENCY) @(posedge clk);
  endtask

  task automatic random_traffic(int unsigned target);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(99) < 80) begin
        // Well-formed message: full words, a short or full closing word.
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 20);
        for (int i = 1; i <= len; i++) begin
          if (i == len) send_word(make_word(random_data(), 4'($urandom_range(1, 8)), 1'b1));
          else send_word(make_word(random_data(), 4'd8, 1'b0));
        end
      end else begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          send_word(make_word(random_data(), 4'($urandom_range(0, 15)),
                              $urandom_range(9) < 3));
        end
      end
      sent += len;
    end
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    load_config(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h1716151413121110,
                64'h1f1e1d1c1b1a1918, 64'h4a000000_09000000, 32'h0);

    // A message that crosses into a second keystream block.
    send_word(make_word(64'h0, 4'd8, 1'b0));
    send_word(make_word(64'hffff_ffff_ffff_ffff, 4'd8, 1'b0));
    for (int i = 0; i < 7; i++) send_word(make_word(random_data(), 4'd8, 1'b0));
    send_word(make_word(random_data(), 4'd3, 1'b1));
    // A new message starts again from counter zero.
    send_word(make_word(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1));
    // No valid bytes, in the middle and at the end of a message.
    send_word(make_word(random_data(), 4'd0, 1'b0));
    send_word(make_word(random_data(), 4'd0, 1'b1));
    // A short word that is not the last still uses up a whole word of keystream.
    send_word(make_word(random_data(), 4'd5, 1'b0));
    send_word(make_word(random_data(), 4'd8, 1'b0));
    send_word(make_word(random_data(), 4'd1, 1'b1));
    // Byte counts above eight mask like eight but are copied through unchanged.
    for (int vb = 9; vb <= 15; vb++) begin
      send_word(make_word(64'hffff_ffff_ffff_ffff, vb[3:0], vb == 15));
    end
    drain_words();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          load_config('0, '0, '0, '0, '0, '0);
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          load_config('1, '1, '1, '1, '1, '1);
          send_idle_pct = 66;
          stall_pct = 0;
        end
        2: begin
          load_config(random_data(), random_data(), random_data(), random_data(),
                      random_data(), $urandom);
          send_idle_pct = 0;
          stall_pct = 66;
        end
        default: begin
          load_config(random_data(), random_data(), random_data(), random_data(),
                      random_data(), $urandom);
          send_idle_pct = 9;
          stall_pct = 9;
        end
      endcase
      random_traffic(195);
      drain_words();
    end

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
